/* src/uwf_pkg.sv */
package uwf_pkg;

	localparam int MAX_LEN    = 1024;
	localparam int DATA_WIDTH = 32;
	localparam int VALUE_W    = 32;
	localparam int IDX_W      = 10;
	localparam int ADDR_W     = $clog2(MAX_LEN);
	localparam int CNT_W      = $clog2(MAX_LEN + 1);

	localparam logic FUNC_LOAD    = 1'b0;
	localparam logic FUNC_COMPUTE = 1'b1;

	typedef logic signed [DATA_WIDTH-1:0] data_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FWD,
		ST_FWD_DRAIN,
		ST_CHECK,
		ST_BWD,
		ST_BWD_DRAIN,
		ST_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic append;
		logic start_fwd;
		logic start_bwd;
		logic issue;
		logic finish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic multi;
		logic scan_last;
		logic found;
		logic out_busy;
	} sts_t;

	// sign extend the input word, then keep the stored width
	function automatic data_t to_data(input logic [VALUE_W-1:0] v);
		logic [VALUE_W+DATA_WIDTH-1:0] ext;
		ext = {{DATA_WIDTH{v[VALUE_W-1]}}, v};
		return data_t'(ext[DATA_WIDTH-1:0]);
	endfunction

	// index onto the fixed output width
	function automatic logic [IDX_W-1:0] to_idx(input logic [ADDR_W-1:0] a);
		logic [IDX_W+ADDR_W-1:0] ext;
		ext = {{IDX_W{1'b0}}, a};
		return ext[IDX_W-1:0];
	endfunction

endpackage

/* src/unsorted_window_finder.sv */
// load transfers may follow back to back; they give no result
// compute with n stored elements: for n < 2 no scan runs; a sorted list gets
// the forward scan only, and the backward scan runs too when a window exists
// the two scans read one element per cycle through the single store read port
// reset clears the element count, the overflow flag and the result valid flag;
// store contents stay undefined and are never read before being written
module unsorted_window_finder (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic                        func,
	input  logic [uwf_pkg::VALUE_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        found,
	output logic [uwf_pkg::IDX_W-1:0]   start_index,
	output logic [uwf_pkg::IDX_W-1:0]   end_index,
	output logic                        overflow
);

	// command and status between sequencer and datapath
	uwf_pkg::cmd_t cmd;
	uwf_pkg::sts_t sts;

	// sequencer: appends on load transfers, then runs the forward scan for the
	// window end and, only if something is out of order, the backward scan for
	// the window start
	uwf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.func    (func),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// datapath: element store, running max/min compare, result register
	uwf_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.value      (value),
		.sts        (sts),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.found      (found),
		.start_index(start_index),
		.end_index  (end_index),
		.overflow   (overflow)
	);

`ifndef NO_ASSERTIONS
	// no window means both indices read zero
	a_empty_window_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !found |-> (start_index == '0) && (end_index == '0))
		else $error("window indices not zero without a window");

	// a compute transfer always holds off the input, whether it starts a scan or goes straight to done
	a_compute_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (func == uwf_pkg::FUNC_COMPUTE) |=> in_stall)
		else $error("input not stalled after compute transfer");

	// a window can only be reported for a list of two or more elements
	a_found_needs_two: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && found |-> $past(sts.multi))
		else $error("window reported for a list shorter than two");
`endif

endmodule

/* src/uwf_ram.sv */
module uwf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

/* src/uwf_dp.sv */
module uwf_dp (
	input  logic                          clk,
	input  logic                          arst_n,
	input  uwf_pkg::cmd_t                 cmd,
	input  logic [uwf_pkg::VALUE_W-1:0]   value,
	output uwf_pkg::sts_t                 sts,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic                          found,
	output logic [uwf_pkg::IDX_W-1:0]     start_index,
	output logic [uwf_pkg::IDX_W-1:0]     end_index,
	output logic                          overflow
);

	logic [uwf_pkg::CNT_W-1:0]  count_q;
	logic [uwf_pkg::CNT_W-1:0]  count_m1;
	logic                       ovf_seen_q;
	logic                       full;
	logic [uwf_pkg::ADDR_W-1:0] addr_q;
	logic                       dir_q;
	logic                       first_q;
	logic                       valid_s1;
	logic                       first_s1;
	logic                       dir_s1;
	logic [uwf_pkg::ADDR_W-1:0] idx_s1;
	uwf_pkg::data_t             rd_data;
	uwf_pkg::data_t             run_q;
	logic                       hit_q;
	logic [uwf_pkg::ADDR_W-1:0] lo_q;
	logic [uwf_pkg::ADDR_W-1:0] hi_q;
	logic                       out_valid_q;
	logic                       found_q;
	logic [uwf_pkg::IDX_W-1:0]  start_q;
	logic [uwf_pkg::IDX_W-1:0]  end_q;
	logic                       overflow_q;
	logic                       fwd_hit;

	assign count_m1 = count_q - uwf_pkg::CNT_W'(1);
	assign full     = (count_q == uwf_pkg::CNT_W'(uwf_pkg::MAX_LEN));
	assign fwd_hit  = valid_s1 && !first_s1 && dir_s1 && (rd_data < run_q);

	uwf_ram #(
		.WIDTH(uwf_pkg::DATA_WIDTH),
		.DEPTH(uwf_pkg::MAX_LEN)
	) u_store (
		.clk    (clk),
		.wr_en  (cmd.append && !full),
		.wr_addr(count_q[uwf_pkg::ADDR_W-1:0]),
		.wr_data(uwf_pkg::to_data(value)),
		.rd_en  (cmd.issue),
		.rd_addr(addr_q),
		.rd_data(rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			ovf_seen_q  <= 1'b0;
			valid_s1    <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= cmd.issue;
			if (cmd.start_fwd) begin
				hit_q <= 1'b0;
			end else if (fwd_hit) begin
				hit_q <= 1'b1;
			end
			if (cmd.append) begin
				if (full) begin
					ovf_seen_q <= 1'b1;
				end else begin
					count_q <= count_q + uwf_pkg::CNT_W'(1);
				end
			end else if (cmd.finish) begin
				count_q    <= '0;
				ovf_seen_q <= 1'b0;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// scan address, read stage and result payload
	always_ff @(posedge clk) begin
		if (cmd.start_fwd) begin
			addr_q  <= '0;
			dir_q   <= 1'b1;
			first_q <= 1'b1;
		end else if (cmd.start_bwd) begin
			addr_q  <= count_m1[uwf_pkg::ADDR_W-1:0];
			dir_q   <= 1'b0;
			first_q <= 1'b1;
		end else if (cmd.issue) begin
			addr_q  <= dir_q ? addr_q + uwf_pkg::ADDR_W'(1) : addr_q - uwf_pkg::ADDR_W'(1);
			first_q <= 1'b0;
		end
		if (cmd.issue) begin
			first_s1 <= first_q;
			dir_s1   <= dir_q;
			idx_s1   <= addr_q;
		end
		if (valid_s1) begin
			if (first_s1) begin
				run_q <= rd_data;
			end else if (dir_s1) begin
				if (rd_data < run_q) begin
					hi_q <= idx_s1;
				end else begin
					run_q <= rd_data;
				end
			end else begin
				if (rd_data > run_q) begin
					lo_q <= idx_s1;
				end else begin
					run_q <= rd_data;
				end
			end
		end
		if (cmd.finish) begin
			found_q    <= hit_q;
			start_q    <= hit_q ? uwf_pkg::to_idx(lo_q) : '0;
			end_q      <= hit_q ? uwf_pkg::to_idx(hi_q) : '0;
			overflow_q <= ovf_seen_q;
		end
	end

	assign sts.multi     = (count_q >= uwf_pkg::CNT_W'(2));
	assign sts.scan_last = dir_q ? (addr_q == count_m1[uwf_pkg::ADDR_W-1:0]) : (addr_q == '0);
	assign sts.found     = hit_q;
	assign sts.out_busy  = out_valid_q;

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign start_index = start_q;
	assign end_index   = end_q;
	assign overflow    = overflow_q;

endmodule

/* src/uwf_ctrl.sv */
module uwf_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic          func,
	output logic          in_stall,
	input  uwf_pkg::sts_t sts,
	output uwf_pkg::cmd_t cmd
);

	uwf_pkg::state_t state_q;
	uwf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uwf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			uwf_pkg::ST_IDLE: begin
				// a compute waits while the previous result is still held
				in_stall = sts.out_busy && (func == uwf_pkg::FUNC_COMPUTE);
				if (in_valid && !in_stall) begin
					if (func == uwf_pkg::FUNC_LOAD) begin
						cmd.append = 1'b1;
					end else begin
						cmd.start_fwd = 1'b1;
						state_d = sts.multi ? uwf_pkg::ST_FWD : uwf_pkg::ST_DONE;
					end
				end
			end
			uwf_pkg::ST_FWD: begin
				cmd.issue = 1'b1;
				if (sts.scan_last) begin
					state_d = uwf_pkg::ST_FWD_DRAIN;
				end
			end
			uwf_pkg::ST_FWD_DRAIN: begin
				state_d = uwf_pkg::ST_CHECK;
			end
			uwf_pkg::ST_CHECK: begin
				if (sts.found) begin
					cmd.start_bwd = 1'b1;
					state_d = uwf_pkg::ST_BWD;
				end else begin
					state_d = uwf_pkg::ST_DONE;
				end
			end
			uwf_pkg::ST_BWD: begin
				cmd.issue = 1'b1;
				if (sts.scan_last) begin
					state_d = uwf_pkg::ST_BWD_DRAIN;
				end
			end
			uwf_pkg::ST_BWD_DRAIN: begin
				state_d = uwf_pkg::ST_DONE;
			end
			uwf_pkg::ST_DONE: begin
				cmd.finish = 1'b1;
				state_d = uwf_pkg::ST_IDLE;
			end
			default: begin
				state_d = uwf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
